// ===== rtl/linear_phase_correction_assert.svh =====
// Assertion macros for the checker file of the phase correction block.
`ifndef LINEAR_PHASE_CORRECTION_ASSERT_SVH
`define LINEAR_PHASE_CORRECTION_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define LPC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("linear_phase_correction: check failed");

// Next-cycle implication, switched off while reset is asserted.
`define LPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("linear_phase_correction: check failed");

// Next-cycle implication that is also checked during reset.
`define LPC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("linear_phase_correction: check failed");

`endif

// ===== rtl/lpc_pkg.sv =====
package lpc_pkg;

    // Sample and line geometry.
    localparam int SAMPLE_BITS = 32;
    localparam int MAX_LINES   = 4096;
    localparam int LINE_W      = $clog2(MAX_LINES);
    localparam int COUNT_W     = LINE_W + 1;
    localparam int SIDX_W      = COUNT_W + 1;

    // Angle and rotator datapath.
    localparam int ANGLE_W       = 32;
    localparam int GUARD_BITS    = 8;
    localparam int DP_W          = SAMPLE_BITS + GUARD_BITS + 4;
    localparam int Z_W           = ANGLE_W + 1;
    localparam int CORDIC_STAGES = 30;

    // Gain compensation.
    localparam int GAIN_W = 32;
    localparam int A_W    = (DP_W > GAIN_W) ? DP_W : GAIN_W + 1;
    localparam int R_W    = A_W - GUARD_BITS;
    localparam logic [GAIN_W-1:0] GAIN_Q32 = 32'd2608131496;

    // Configuration port.
    localparam int CFG_W     = ANGLE_W;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT = 2'd2;

    // Arctangent of 2^-i in units of 2^-32 turn, rounded to nearest.
    localparam logic [ANGLE_W-1:0] ATAN_TURN [CORDIC_STAGES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_re;
        logic signed [SAMPLE_BITS-1:0] sample_im;
        logic [LINE_W-1:0]             line_index;
    } lpc_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_re;
        logic signed [SAMPLE_BITS-1:0] out_im;
    } lpc_out_t;

    // Control that travels down the pipeline with each beat.
    typedef struct packed {
        logic valid;
        logic bypass;
    } lpc_ctl_t;

    typedef struct packed {
        logic signed [DP_W-1:0] x;
        logic signed [DP_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } lpc_rot_t;

    typedef struct packed {
        logic signed [DP_W-1:0] x;
        logic signed [DP_W-1:0] y;
    } lpc_xy_t;

endpackage

// ===== rtl/lpc_angle.sv =====
module lpc_angle (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               adv,
    input  logic                               in_valid,
    input  lpc_pkg::lpc_in_t                   in_data,
    input  logic                               cfg_enable,
    input  logic signed [lpc_pkg::ANGLE_W-1:0] phase_step,
    input  logic [lpc_pkg::COUNT_W-1:0]        line_count,
    output lpc_pkg::lpc_ctl_t                  ctl_out,
    output lpc_pkg::lpc_rot_t                  rot_out
);
    import lpc_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_LINES);
    localparam logic [ANGLE_W-1:0] QUARTER   = ANGLE_W'(1) << (ANGLE_W - 2);

    lpc_ctl_t ctl1_reg, ctl2_reg, ctl3_reg;
    lpc_ctl_t ctl1_next;

    logic signed [SAMPLE_BITS-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [SIDX_W-1:0]      sidx1_reg, sidx1_next;
    logic [ANGLE_W-1:0]            angle2_reg, angle2_next;
    lpc_rot_t                      rot3_reg, rot3_next;

    logic [COUNT_W-1:0]                lc_sat;
    logic [COUNT_W-1:0]                j_ext;
    logic signed [ANGLE_W+SIDX_W-1:0]  prod;
    logic [ANGLE_W-1:0]                angle_q;
    logic                              fold;
    logic signed [DP_W-1:0]            x_scaled, y_scaled;

    // Stage 1: signed line index, upper half maps to negative lines.
    always_comb begin
        lc_sat     = (line_count > MAX_COUNT) ? MAX_COUNT : line_count;
        j_ext      = COUNT_W'(in_data.line_index);
        sidx1_next = (j_ext >= (lc_sat >> 1))
                   ? $signed({1'b0, j_ext}) - $signed({1'b0, lc_sat})
                   : $signed({1'b0, j_ext});
        ctl1_next  = '{valid: in_valid, bypass: !cfg_enable};
    end

    // Stage 2: angle as step times signed index, modulo one turn.
    always_comb begin
        prod        = phase_step * sidx1_reg;
        angle2_next = prod[ANGLE_W-1:0];
    end

    // Stage 3: fold the left half plane onto the right, scale in guard bits.
    always_comb begin
        angle_q  = angle2_reg + QUARTER;
        fold     = angle_q[ANGLE_W-1] && !ctl2_reg.bypass;
        x_scaled = $signed({{(DP_W-SAMPLE_BITS-GUARD_BITS){x2_reg[SAMPLE_BITS-1]}},
                            x2_reg, {GUARD_BITS{1'b0}}});
        y_scaled = $signed({{(DP_W-SAMPLE_BITS-GUARD_BITS){y2_reg[SAMPLE_BITS-1]}},
                            y2_reg, {GUARD_BITS{1'b0}}});
        if (ctl2_reg.bypass) begin
            rot3_next = '{x: x_scaled, y: y_scaled, z: '0};
        end else if (fold) begin
            rot3_next = '{x: -x_scaled, y: -y_scaled,
                          z: $signed({~angle2_reg[ANGLE_W-1], ~angle2_reg[ANGLE_W-1],
                                      angle2_reg[ANGLE_W-2:0]})};
        end else begin
            rot3_next = '{x: x_scaled, y: y_scaled,
                          z: $signed({angle2_reg[ANGLE_W-1], angle2_reg})};
        end
    end

    // Control of the three stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end else if (adv) begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    // Payload of the three stages.
    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_reg     <= in_data.sample_re;
            y1_reg     <= in_data.sample_im;
            sidx1_reg  <= sidx1_next;
            x2_reg     <= x1_reg;
            y2_reg     <= y1_reg;
            angle2_reg <= angle2_next;
            rot3_reg   <= rot3_next;
        end
    end

    assign ctl_out = ctl3_reg;
    assign rot_out = rot3_reg;

endmodule

// ===== rtl/lpc_cordic.sv =====
module lpc_cordic (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  lpc_pkg::lpc_ctl_t ctl_in,
    input  lpc_pkg::lpc_rot_t rot_in,
    output lpc_pkg::lpc_ctl_t ctl_out,
    output lpc_pkg::lpc_xy_t  xy_out
);
    import lpc_pkg::*;

    lpc_ctl_t               ctl_reg [CORDIC_STAGES];
    logic signed [DP_W-1:0] x_reg   [CORDIC_STAGES];
    logic signed [DP_W-1:0] y_reg   [CORDIC_STAGES];
    logic signed [Z_W-1:0]  z_reg   [CORDIC_STAGES];
    lpc_ctl_t               ctl_next [CORDIC_STAGES];
    logic signed [DP_W-1:0] x_next  [CORDIC_STAGES];
    logic signed [DP_W-1:0] y_next  [CORDIC_STAGES];
    logic signed [Z_W-1:0]  z_next  [CORDIC_STAGES];

    // One micro-rotation per register stage; a bypassed beat passes untouched.
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        logic signed [DP_W-1:0] x_in, y_in, dx, dy;
        logic signed [Z_W-1:0]  z_in, atan_z;
        lpc_ctl_t               c_in;

        if (i == 0) begin : g_first
            assign x_in = rot_in.x;
            assign y_in = rot_in.y;
            assign z_in = rot_in.z;
            assign c_in = ctl_in;
        end else begin : g_rest
            assign x_in = x_reg[i-1];
            assign y_in = y_reg[i-1];
            assign z_in = z_reg[i-1];
            assign c_in = ctl_reg[i-1];
        end

        assign dx     = y_in >>> i;
        assign dy     = x_in >>> i;
        assign atan_z = $signed({1'b0, ATAN_TURN[i]});

        always_comb begin
            ctl_next[i] = c_in;
            if (c_in.bypass) begin
                x_next[i] = x_in;
                y_next[i] = y_in;
                z_next[i] = z_in;
            end else if (!z_in[Z_W-1]) begin
                x_next[i] = x_in - dx;
                y_next[i] = y_in + dy;
                z_next[i] = z_in - atan_z;
            end else begin
                x_next[i] = x_in + dx;
                y_next[i] = y_in - dy;
                z_next[i] = z_in + atan_z;
            end
        end
    end

    // Valid and bypass flags of every stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < CORDIC_STAGES; k++) begin
                ctl_reg[k] <= '0;
            end
        end else if (adv) begin
            for (int k = 0; k < CORDIC_STAGES; k++) begin
                ctl_reg[k] <= ctl_next[k];
            end
        end
    end

    // Vector and residual angle of every stage.
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < CORDIC_STAGES; k++) begin
                x_reg[k] <= x_next[k];
                y_reg[k] <= y_next[k];
                z_reg[k] <= z_next[k];
            end
        end
    end

    assign ctl_out = ctl_reg[CORDIC_STAGES-1];
    assign xy_out  = '{x: x_reg[CORDIC_STAGES-1], y: y_reg[CORDIC_STAGES-1]};

endmodule

// ===== rtl/lpc_gain.sv =====
module lpc_gain (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  lpc_pkg::lpc_ctl_t ctl_in,
    input  lpc_pkg::lpc_xy_t  xy_in,
    output logic              out_valid,
    output lpc_pkg::lpc_out_t out_data
);
    import lpc_pkg::*;

    localparam logic [A_W-1:0] ROUND_HALF = A_W'(1) << (GUARD_BITS - 1);
    localparam logic [R_W-1:0] SAT_POS    = (R_W'(1) << (SAMPLE_BITS - 1)) - R_W'(1);
    localparam logic [R_W-1:0] SAT_NEG    = R_W'(1) << (SAMPLE_BITS - 1);
    localparam logic [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    lpc_ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;

    logic signed [DP_W-1:0]        v_in   [2];
    logic [SAMPLE_BITS-1:0]        res4_reg [2];

    assign v_in[0] = xy_in.x;
    assign v_in[1] = xy_in.y;

    // Both lanes: magnitude, split multiply, round, then sign and saturate; bypass skips the multiply.
    for (genvar ln = 0; ln < 2; ln++) begin : g_lane
        logic                    neg1_reg, neg2_reg, neg3_reg;
        logic [A_W-1:0]          a1_reg, a1_next;
        logic [DP_W-1:0]         mag;
        logic [2*GAIN_W-1:0]     plo2_reg, plo2_next;
        logic [A_W-1:0]          phi2_reg, phi2_next;
        logic [R_W-1:0]          byp2_reg;
        logic [A_W-1:0]          mid;
        logic [R_W-1:0]          r3_reg, r3_next;
        logic [SAMPLE_BITS-1:0]  res4_next;

        always_comb begin
            mag       = v_in[ln][DP_W-1] ? DP_W'(-v_in[ln]) : DP_W'(v_in[ln]);
            a1_next   = A_W'(mag);
            plo2_next = a1_reg[GAIN_W-1:0] * GAIN_Q32;
            phi2_next = a1_reg[A_W-1:GAIN_W] * GAIN_Q32;
            mid       = A_W'(plo2_reg[2*GAIN_W-1:GAIN_W]) + phi2_reg + ROUND_HALF;
            r3_next   = ctl2_reg.bypass ? byp2_reg : mid[A_W-1:GUARD_BITS];
            if (neg3_reg) begin
                res4_next = (r3_reg > SAT_NEG) ? OUT_MIN : -r3_reg[SAMPLE_BITS-1:0];
            end else begin
                res4_next = (r3_reg > SAT_POS) ? OUT_MAX : r3_reg[SAMPLE_BITS-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                neg1_reg     <= v_in[ln][DP_W-1];
                a1_reg       <= a1_next;
                neg2_reg     <= neg1_reg;
                plo2_reg     <= plo2_next;
                phi2_reg     <= phi2_next;
                byp2_reg     <= a1_reg[A_W-1:GUARD_BITS];
                neg3_reg     <= neg2_reg;
                r3_reg       <= r3_next;
                res4_reg[ln] <= res4_next;
            end
        end
    end

    // Valid and bypass flags of the four stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end else if (adv) begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    assign out_valid = ctl4_reg.valid;
    assign out_data  = '{out_re: $signed(res4_reg[0]), out_im: $signed(res4_reg[1])};

endmodule

// ===== rtl/linear_phase_correction.sv =====
// Channel   Direction  Handshake        Beat contents
// s_        in         s_valid/s_ready  sample_re, sample_im, line_index
// m_        out        m_valid/m_ready  out_re, out_im
// cfg_      in         cfg_we           cfg_index selects, cfg_wdata carries
//
// One beat per cycle while s_ready is high; 37 stages (3 angle, 30 rotator, 4 gain)
// advance together and hand each result on to the output register.
// Reset (aresetn low, synchronous) clears the valid flags and loads enable 0,
// phase_step 0 and line_count 4096.
// A held-off result waits in the output register and the next in a skid
// register; only then does s_ready drop and the whole pipeline freeze.
module linear_phase_correction (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [lpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lpc_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  lpc_pkg::lpc_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output lpc_pkg::lpc_out_t                   m_data
);
    import lpc_pkg::*;

    logic                       enable_reg;
    logic signed [ANGLE_W-1:0]  phase_step_reg;
    logic [COUNT_W-1:0]         line_count_reg;

    logic      adv;
    lpc_ctl_t  ang_ctl, rot_ctl;
    lpc_rot_t  ang_rot;
    lpc_xy_t   rot_xy;
    logic      pipe_valid;
    lpc_out_t  pipe_data;

    lpc_out_t  out_reg, skid_reg;
    logic      out_valid_reg, skid_valid_reg;
    logic      take, handoff;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg     <= 1'b0;
            phase_step_reg <= '0;
            line_count_reg <= COUNT_W'(MAX_LINES);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ENABLE:     enable_reg     <= cfg_wdata[0];
                CFG_PHASE_STEP: phase_step_reg <= $signed(cfg_wdata[ANGLE_W-1:0]);
                CFG_LINE_COUNT: line_count_reg <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances while the skid register is free.
    assign adv     = !skid_valid_reg;
    assign s_ready = adv;

    lpc_angle u_angle (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (s_valid),
        .in_data    (s_data),
        .cfg_enable (enable_reg),
        .phase_step (phase_step_reg),
        .line_count (line_count_reg),
        .ctl_out    (ang_ctl),
        .rot_out    (ang_rot)
    );

    lpc_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .ctl_in  (ang_ctl),
        .rot_in  (ang_rot),
        .ctl_out (rot_ctl),
        .xy_out  (rot_xy)
    );

    lpc_gain u_gain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .ctl_in    (rot_ctl),
        .xy_in     (rot_xy),
        .out_valid (pipe_valid),
        .out_data  (pipe_data)
    );

    // Output register with a skid register behind it.
    assign take    = out_valid_reg && m_ready;
    assign handoff = adv && pipe_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (handoff) begin
            if (!out_valid_reg || take) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (take) begin
                out_reg <= skid_reg;
            end
        end else if (handoff) begin
            if (!out_valid_reg || take) begin
                out_reg <= pipe_data;
            end else begin
                skid_reg <= pipe_data;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== rtl/lpc_checker.sv =====
`include "linear_phase_correction_assert.svh"

module lpc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input lpc_pkg::lpc_in_t              s_data,
    input logic                          m_valid,
    input logic                          m_ready,
    input lpc_pkg::lpc_out_t             m_data
);
    import lpc_pkg::*;

    // A stalled result beat holds.
    `LPC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // Reset empties the output and opens the input.
    `LPC_ASSERT_NEXT_ALWAYS(a_reset_state, aclk, !aresetn, !m_valid && s_ready)

    // The input only closes while a result is waiting.
    `LPC_ASSERT_IMPLY(a_stall_has_result, aclk, aresetn, !s_ready, m_valid)

    // The input closes only after the output was held back.
    `LPC_ASSERT_IMPLY(a_stall_cause, aclk, aresetn, $fell(s_ready), $past(m_valid && !m_ready))

endmodule

bind linear_phase_correction lpc_checker u_lpc_checker (.*);
